// File: hdl/clsle_pkg.sv
package clsle_pkg;

    // Field widths
    localparam int CNT_W = 32;
    localparam int CLS_W = 4;
    localparam int TOT_W = CNT_W + 1;

    // Saturated running total: sticks at 2^32 once the sum passes the count range
    localparam logic [TOT_W-1:0] TOT_SAT = {1'b1, {CNT_W{1'b0}}};

    // Reset value of the minimum support register
    localparam logic [CNT_W-1:0] MIN_SUPPORT_RST = CNT_W'(1);

    // One class of a node
    typedef struct packed {
        logic [CNT_W-1:0] class_support;
        logic [CNT_W-1:0] global_support;
        logic             last_class;
    } t_req;

    // One leaf evaluation
    typedef struct packed {
        logic [CNT_W-1:0] leaf_error;
        logic [CLS_W-1:0] majority_class;
        logic             is_frequent;
        logic             is_pure_bound;
        logic             total_saturated;
    } t_res;

    // Node summary handed from the update stage to the result stage
    typedef struct packed {
        logic [TOT_W-1:0] total;
        logic [CNT_W-1:0] best_support;
        logic [CLS_W-1:0] best_class;
        logic [CNT_W-1:0] second_support;
    } t_fin;

endpackage

// File: hdl/clsle_update.sv
module clsle_update
    import clsle_pkg::*;
#(
    parameter int MAX_CLASSES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_fin_valid,
    output t_fin o_fin
);

    localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CLASSES - 1);

    // Running node state
    logic [IDX_W-1:0] r_idx,    n_idx;
    logic [CNT_W-1:0] r_best,   n_best;
    logic [IDX_W-1:0] r_cls,    n_cls;
    logic [CNT_W-1:0] r_glob,   n_glob;
    logic [CNT_W-1:0] r_second, n_second;
    logic [TOT_W-1:0] r_total,  n_total;

    logic             r_fin_valid;
    t_fin             r_fin;

    logic [TOT_W:0]   sum;

    // Compare the new class against the running maximum and second maximum
    always_comb begin
        n_best   = r_best;
        n_cls    = r_cls;
        n_glob   = r_glob;
        n_second = r_second;
        if (r_idx == '0) begin
            n_best   = i_req.class_support;
            n_cls    = '0;
            n_glob   = i_req.global_support;
            n_second = '0;
        end else if (i_req.class_support > r_best) begin
            n_second = r_best;
            n_best   = i_req.class_support;
            n_cls    = r_idx;
            n_glob   = i_req.global_support;
        end else begin
            if (i_req.class_support > r_second) begin
                n_second = i_req.class_support;
            end
            // Equal support: larger dataset-wide support takes the majority
            if (i_req.class_support == r_best && i_req.global_support > r_glob) begin
                n_cls  = r_idx;
                n_glob = i_req.global_support;
            end
        end

        // Accumulate and clamp the total
        sum = {1'b0, r_total} + (TOT_W+1)'(i_req.class_support);
        if (sum > {1'b0, TOT_SAT}) begin
            n_total = TOT_SAT;
        end else begin
            n_total = sum[TOT_W-1:0];
        end

        // Advance the class number, holding at the last slot
        if (r_idx < IDX_LAST) begin
            n_idx = r_idx + IDX_W'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    // Store node state; clear it after the last class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_best   <= '0;
            r_cls    <= '0;
            r_glob   <= '0;
            r_second <= '0;
            r_total  <= '0;
        end else if (i_valid) begin
            if (i_req.last_class) begin
                r_idx    <= '0;
                r_best   <= '0;
                r_cls    <= '0;
                r_glob   <= '0;
                r_second <= '0;
                r_total  <= '0;
            end else begin
                r_idx    <= n_idx;
                r_best   <= n_best;
                r_cls    <= n_cls;
                r_glob   <= n_glob;
                r_second <= n_second;
                r_total  <= n_total;
            end
        end
    end

    // Capture the node summary on the last class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= i_valid && i_req.last_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_req.last_class) begin
            r_fin.total          <= n_total;
            r_fin.best_support   <= n_best;
            r_fin.best_class     <= CLS_W'(n_cls);
            r_fin.second_support <= n_second;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

// File: hdl/clsle_result.sv
module clsle_result
    import clsle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fin_valid,
    input  t_fin             i_fin,
    input  logic [CNT_W-1:0] i_min_support,
    output logic             o_done,
    output t_res             o_res
);

    logic             sat;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] err;
    logic [CNT_W:0]   bound;
    t_res             n_res;
    logic             r_done;
    t_res             r_res;

    // Derive the leaf figures from the node summary
    always_comb begin
        sat   = i_fin.total[CNT_W];
        total = sat ? '1 : i_fin.total[CNT_W-1:0];
        err   = total - i_fin.best_support;
        bound = {1'b0, err} + {1'b0, i_fin.second_support};

        n_res.leaf_error      = err;
        n_res.majority_class  = i_fin.best_class;
        n_res.is_frequent     = total >= i_min_support;
        n_res.is_pure_bound   = {1'b0, i_min_support} > bound;
        n_res.total_saturated = sat;
    end

    // Strobe the result for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fin_valid) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: hdl/class_support_leaf_evaluator.sv
// Path: the result strobe o_done follows the edge that accepts the last class of a
//   node through the input register, the node update and the result register.
// Throughput: one class request per cycle, every cycle; busy is low whenever not in reset.
// Reset: synchronous, active low; clears the node state and sets min_support to 1.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module class_support_leaf_evaluator
    import clsle_pkg::*;
#(
    parameter int MAX_CLASSES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output t_res             o_res
);

    logic [CNT_W-1:0] r_min;
    logic             r_in_valid;
    t_req             r_in;
    logic             fin_valid;
    t_fin             fin;

    // Hold off requests only while in reset
    assign busy = !i_rst_n;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_SUPPORT_RST;
        end else if (i_cfg_we) begin
            r_min <= i_cfg_wdata;
        end
    end

    // Register the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_req;
        end
    end

    clsle_update #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_req       (r_in),
        .o_fin_valid (fin_valid),
        .o_fin       (fin)
    );

    clsle_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fin_valid   (fin_valid),
        .i_fin         (fin),
        .i_min_support (r_min),
        .o_done        (o_done),
        .o_res         (o_res)
    );

endmodule

// File: hdl/clsle_checker.sv
module clsle_checker
    import clsle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_req i_req,
    input  logic o_done,
    input  t_res o_res
);

    logic accept;
    assign accept = start && !busy;

    // An accepted last class always yields a result strobe
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.last_class) |=> ##2 o_done)
        else $error("last class request produced no result");

    // A class that is not last never yields a result
    a_mid_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_req.last_class) |=> ##2 !o_done)
        else $error("result after a class that was not last");

    // Every result traces back to a last class request
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept && i_req.last_class, 3))
        else $error("result without a matching last class request");

    // A saturated total covers any minimum support
    a_sat_is_frequent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.total_saturated) |-> o_res.is_frequent)
        else $error("saturated total reported as not frequent");

endmodule

bind class_support_leaf_evaluator clsle_checker u_clsle_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_res   (o_res)
);
